### hdl/plhc_pkg.sv
// Shared types and constants for the presence light hold controller.
package plhc_pkg;

	// Operation codes carried on the slave tuser
	typedef enum logic [2:0] {
		OP_UPDATE   = 3'd0,
		OP_TURN_ON  = 3'd1,
		OP_TURN_OFF = 3'd2,
		OP_TOGGLE   = 3'd3,
		OP_SET_AUTO = 3'd4
	} op_t;

	// Register indexes (paddr[2])
	localparam logic REG_LIGHT_INSTALLED = 1'b0;
	localparam logic REG_HOLD_SECONDS    = 1'b1;

	localparam int HOLD_SEC_W = 9;
	localparam int HOLD_MS_W  = 19;  // 511 * 1000 fits in 19 bits
	localparam int TIME_W     = 32;
	localparam logic [9:0] MS_PER_SECOND = 10'd1000;

	localparam logic [HOLD_SEC_W-1:0] HOLD_SECONDS_RST = 9'd30;

	// One input word, unpacked
	typedef struct packed {
		logic [2:0]        operation;
		logic              radar_online;
		logic              occupied;
		logic [TIME_W-1:0] now_ms;
		logic              auto_enable;
	} item_t;

	// One result word
	typedef struct packed {
		logic light_on;
		logic changed;
		logic auto_active;
	} result_t;

	// Configuration seen by the core
	typedef struct packed {
		logic                 light_installed;
		logic [HOLD_MS_W-1:0] hold_ms;
	} cfg_t;

endpackage

### hdl/plhc_cfg.sv
// APB register file: light fitted flag and hold time, with hold in ms precomputed.
module plhc_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output plhc_pkg::cfg_t cfg
);

	logic                                 light_installed_q;
	logic [plhc_pkg::HOLD_SEC_W-1:0]      hold_seconds_q;
	logic [plhc_pkg::HOLD_MS_W-1:0]       hold_ms_q;
	logic                                 wr_en;
	logic [plhc_pkg::HOLD_MS_W-1:0]       hold_ms_new;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// seconds to ms, done once at write time
	assign hold_ms_new = plhc_pkg::HOLD_MS_W'(pwdata[plhc_pkg::HOLD_SEC_W-1:0])
		* plhc_pkg::HOLD_MS_W'(plhc_pkg::MS_PER_SECOND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_installed_q <= 1'b1;
			hold_seconds_q    <= plhc_pkg::HOLD_SECONDS_RST;
			hold_ms_q         <= plhc_pkg::HOLD_MS_W'(plhc_pkg::HOLD_SECONDS_RST)
				* plhc_pkg::HOLD_MS_W'(plhc_pkg::MS_PER_SECOND);
		end else if (wr_en) begin
			unique case (paddr[2])
				plhc_pkg::REG_LIGHT_INSTALLED: begin
					light_installed_q <= pwdata[0];
				end
				plhc_pkg::REG_HOLD_SECONDS: begin
					hold_seconds_q <= pwdata[plhc_pkg::HOLD_SEC_W-1:0];
					hold_ms_q      <= hold_ms_new;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			plhc_pkg::REG_LIGHT_INSTALLED: prdata = {31'd0, light_installed_q};
			plhc_pkg::REG_HOLD_SECONDS:    prdata = {23'd0, hold_seconds_q};
			default:                       prdata = 32'd0;
		endcase
	end

	assign cfg.light_installed = light_installed_q;
	assign cfg.hold_ms         = hold_ms_q;

endmodule

### hdl/plhc_core.sv
// Light state registers and the next-state logic for one operation.
module plhc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  plhc_pkg::item_t   item,
	input  plhc_pkg::cfg_t    cfg,
	output plhc_pkg::result_t result
);

	logic                          manual_on_q, light_state_q, occupied_now_q;
	logic                          suppress_q, auto_mode_q;
	logic [plhc_pkg::TIME_W-1:0]   last_ms_q;

	logic                          manual_on_d, light_state_d, occupied_now_d;
	logic                          suppress_d, auto_mode_d;
	logic [plhc_pkg::TIME_W-1:0]   last_ms_d;

	logic                          occ_upd, sup_upd, held;
	logic [plhc_pkg::TIME_W-1:0]   last_upd, age_ms;

	// update path pieces
	assign occ_upd  = item.radar_online && item.occupied;
	assign sup_upd  = occ_upd ? suppress_q : 1'b0;
	assign last_upd = occ_upd ? item.now_ms
		: (suppress_q ? '0 : last_ms_q);
	assign age_ms   = item.now_ms - last_upd;
	assign held     = (last_upd != '0)
		&& (age_ms <= plhc_pkg::TIME_W'(cfg.hold_ms));

	always_comb begin
		manual_on_d    = manual_on_q;
		light_state_d  = light_state_q;
		occupied_now_d = occupied_now_q;
		suppress_d     = suppress_q;
		auto_mode_d    = auto_mode_q;
		last_ms_d      = last_ms_q;
		unique case (plhc_pkg::op_t'(item.operation))
			plhc_pkg::OP_UPDATE: begin
				if (!cfg.light_installed) begin
					occupied_now_d = 1'b0;
					light_state_d  = 1'b0;
				end else begin
					occupied_now_d = occ_upd;
					suppress_d     = sup_upd;
					last_ms_d      = last_upd;
					light_state_d  = manual_on_q
						|| (auto_mode_q && !sup_upd && (occ_upd || held));
				end
			end
			plhc_pkg::OP_TURN_ON: begin
				manual_on_d   = 1'b1;
				suppress_d    = 1'b0;
				light_state_d = 1'b1;
			end
			plhc_pkg::OP_TURN_OFF: begin
				manual_on_d   = 1'b0;
				suppress_d    = occupied_now_q;
				last_ms_d     = '0;
				light_state_d = 1'b0;
			end
			plhc_pkg::OP_TOGGLE: begin
				if (light_state_q) begin
					manual_on_d   = 1'b0;
					suppress_d    = occupied_now_q;
					last_ms_d     = '0;
					light_state_d = 1'b0;
				end else begin
					manual_on_d   = 1'b1;
					suppress_d    = 1'b0;
					light_state_d = 1'b1;
				end
			end
			plhc_pkg::OP_SET_AUTO: begin
				auto_mode_d = item.auto_enable;
				if (!item.auto_enable) begin
					suppress_d    = 1'b0;
					last_ms_d     = '0;
					light_state_d = manual_on_q;
				end else begin
					light_state_d = manual_on_q || (!suppress_q && occupied_now_q);
				end
			end
			default: ;  // unused codes leave state alone
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manual_on_q    <= 1'b0;
			light_state_q  <= 1'b0;
			occupied_now_q <= 1'b0;
			suppress_q     <= 1'b0;
			auto_mode_q    <= 1'b1;
			last_ms_q      <= '0;
		end else if (fire) begin
			manual_on_q    <= manual_on_d;
			light_state_q  <= light_state_d;
			occupied_now_q <= occupied_now_d;
			suppress_q     <= suppress_d;
			auto_mode_q    <= auto_mode_d;
			last_ms_q      <= last_ms_d;
		end
	end

	assign result.light_on    = light_state_d;
	assign result.changed     = light_state_d != light_state_q;
	assign result.auto_active = auto_mode_d;

endmodule

### hdl/presence_light_hold_controller.sv
// Top level: input word register, core state update, result register.
// From input accept to result valid a word passes the input reg, then the result reg.
// Throughput: one word per cycle while m_tready stays high; the core updates all state
//   for each word it takes, so back-to-back words see the state left by the word before.
// Reset (arst_n, async, active low): pipeline empty, light off, manual off,
//   no occupancy, no suppression, no presence time, automatic mode on,
//   light_installed 1, hold_seconds 30.
module presence_light_hold_controller (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [0] radar_online, [1] occupied, [33:2] now_ms,
	                              // [34] auto_enable, [39:35] zero
	input  logic [2:0]  s_tuser,  // [2:0] operation
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [0] light_on, [1] changed, [2] auto_active,
	                              // [7:3] zero
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	plhc_pkg::cfg_t    cfg;
	plhc_pkg::item_t   item_s1;
	plhc_pkg::result_t res_d, res_s2;
	logic              valid_s1, valid_s2;
	logic              adv;

	// word in stage 1 moves on when the result register is free or draining
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.operation    <= s_tuser;
			item_s1.radar_online <= s_tdata[0];
			item_s1.occupied     <= s_tdata[1];
			item_s1.now_ms       <= s_tdata[33:2];
			item_s1.auto_enable  <= s_tdata[34];
		end
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	plhc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	plhc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_d)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, res_s2.auto_active, res_s2.changed, res_s2.light_on};

endmodule

### tb/tb.sv
// Self-checking testbench for presence_light_hold_controller: directed plan, random traffic.
module tb;

	typedef plhc_pkg::item_t   item_t;
	typedef plhc_pkg::result_t result_t;

	localparam plhc_pkg::op_t OP_UPDATE   = plhc_pkg::OP_UPDATE;
	localparam plhc_pkg::op_t OP_TURN_ON  = plhc_pkg::OP_TURN_ON;
	localparam plhc_pkg::op_t OP_TURN_OFF = plhc_pkg::OP_TURN_OFF;
	localparam plhc_pkg::op_t OP_TOGGLE   = plhc_pkg::OP_TOGGLE;
	localparam plhc_pkg::op_t OP_SET_AUTO = plhc_pkg::OP_SET_AUTO;
	localparam logic REG_LIGHT_INSTALLED  = plhc_pkg::REG_LIGHT_INSTALLED;
	localparam logic REG_HOLD_SECONDS     = plhc_pkg::REG_HOLD_SECONDS;

	localparam int IDLE_LIMIT  = 3000;  // cycles with no word moving on either stream
	localparam int HOLD_OFF    = 300;   // long receiver stall used to back up the input
	localparam int PLAN_ROWS   = 26;
	localparam int PHASES      = 8;
	// Codes past the defined operations; the block must leave its state alone
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // [0] radar_online, [1] occupied, [33:2] now_ms,
	                        // [34] auto_enable, [39:35] zero
	logic [2:0]  s_tuser;   // [2:0] operation
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [0] light_on, [1] changed, [2] auto_active, [7:3] zero
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	presence_light_hold_controller dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Light controller mirror: registers and state as left by the last accepted word
	logic        fitted          = 1'b1;
	logic [8:0]  hold_s          = 9'd30;
	logic        hand_on         = 1'b0;
	logic        lamp_lit        = 1'b0;
	logic        room_busy       = 1'b0;
	logic        hush_until_clear = 1'b0;
	logic [31:0] seen_ms         = 32'd0;
	logic        auto_mode_on    = 1'b1;

	result_t     expected_lights [$];
	int          fault_count     = 0;
	int          checked_results = 0;
	int          sent_words      = 0;
	int          cfg_writes      = 0;
	int          in_stalls       = 0;
	int          op_seen [8];
	int          stall_requests  = 0;

	// Random traffic shaping
	logic [31:0] sim_ms;
	logic        busy_run;

	typedef struct packed {
		logic [2:0]  op;
		logic        radar;
		logic        occ;
		logic [31:0] now;
		logic        en;
		logic        cfg;    // drain and rewrite registers before this word
		logic        fit;
		logic [8:0]  hold;
		logic        typed;  // expectation given below rather than predicted
		result_t     want;
	} plan_row_t;

	// Directed plan. Hold is 30 s until the register rows near the end.
	plan_row_t plan [PLAN_ROWS] = '{
		// presence at time zero stores nothing, so the next empty update drops the light
		'{OP_UPDATE,   1'b1, 1'b1, 32'd0,          1'b0, 1'b0, 1'b1, 9'd30,  1'b1, '{1'b1, 1'b1, 1'b1}},
		'{OP_UPDATE,   1'b1, 1'b0, 32'd1000,       1'b1, 1'b0, 1'b1, 9'd30,  1'b1, '{1'b0, 1'b1, 1'b1}},
		// presence at the top of the clock, then the hold test across the wrap
		'{OP_UPDATE,   1'b1, 1'b1, 32'hFFFF_FFFF,  1'b0, 1'b0, 1'b1, 9'd30,  1'b1, '{1'b1, 1'b1, 1'b1}},
		'{OP_UPDATE,   1'b1, 1'b0, 32'd5,          1'b1, 1'b0, 1'b1, 9'd30,  1'b1, '{1'b1, 1'b0, 1'b1}},
		// exactly the hold time (radar offline), then one ms past it
		'{OP_UPDATE,   1'b0, 1'b1, 32'd29999,      1'b0, 1'b0, 1'b1, 9'd30,  1'b1, '{1'b1, 1'b0, 1'b1}},
		'{OP_UPDATE,   1'b1, 1'b0, 32'd30000,      1'b0, 1'b0, 1'b1, 9'd30,  1'b1, '{1'b0, 1'b1, 1'b1}},
		'{OP_TURN_ON,  1'b1, 1'b1, 32'hFFFF_FFFF,  1'b1, 1'b0, 1'b1, 9'd30,  1'b1, '{1'b1, 1'b1, 1'b1}},
		'{OP_TURN_OFF, 1'b0, 1'b0, 32'd0,          1'b0, 1'b0, 1'b1, 9'd30,  1'b0, '{1'b0, 1'b0, 1'b0}},
		// turn off while occupied: suppressed until the room is seen empty
		'{OP_UPDATE,   1'b1, 1'b1, 32'd100,        1'b0, 1'b0, 1'b1, 9'd30,  1'b0, '{1'b0, 1'b0, 1'b0}},
		'{OP_TURN_OFF, 1'b1, 1'b0, 32'd7,          1'b1, 1'b0, 1'b1, 9'd30,  1'b0, '{1'b0, 1'b0, 1'b0}},
		'{OP_UPDATE,   1'b1, 1'b1, 32'd200,        1'b0, 1'b0, 1'b1, 9'd30,  1'b0, '{1'b0, 1'b0, 1'b0}},
		'{OP_UPDATE,   1'b1, 1'b0, 32'd300,        1'b0, 1'b0, 1'b1, 9'd30,  1'b0, '{1'b0, 1'b0, 1'b0}},
		'{OP_UPDATE,   1'b1, 1'b1, 32'd400,        1'b0, 1'b0, 1'b1, 9'd30,  1'b0, '{1'b0, 1'b0, 1'b0}},
		// toggle both ways
		'{OP_TOGGLE,   1'b0, 1'b1, 32'd0,          1'b0, 1'b0, 1'b1, 9'd30,  1'b0, '{1'b0, 1'b0, 1'b0}},
		'{OP_TOGGLE,   1'b1, 1'b0, 32'd0,          1'b1, 1'b0, 1'b1, 9'd30,  1'b0, '{1'b0, 1'b0, 1'b0}},
		// automatic mode off and back on
		'{OP_SET_AUTO, 1'b1, 1'b1, 32'd0,          1'b0, 1'b0, 1'b1, 9'd30,  1'b0, '{1'b0, 1'b0, 1'b0}},
		'{OP_TURN_OFF, 1'b0, 1'b0, 32'd0,          1'b0, 1'b0, 1'b1, 9'd30,  1'b0, '{1'b0, 1'b0, 1'b0}},
		'{OP_UPDATE,   1'b1, 1'b1, 32'd500,        1'b1, 1'b0, 1'b1, 9'd30,  1'b0, '{1'b0, 1'b0, 1'b0}},
		'{OP_SET_AUTO, 1'b0, 1'b0, 32'd0,          1'b1, 1'b0, 1'b1, 9'd30,  1'b0, '{1'b0, 1'b0, 1'b0}},
		// unused operation codes at both ends of the spare range
		'{OP_SPARE_LO, 1'b0, 1'b0, 32'd0,          1'b0, 1'b0, 1'b1, 9'd30,  1'b1, '{1'b0, 1'b0, 1'b1}},
		'{OP_SPARE_HI, 1'b1, 1'b1, 32'hFFFF_FFFF,  1'b1, 1'b0, 1'b1, 9'd30,  1'b1, '{1'b0, 1'b0, 1'b1}},
		'{OP_UPDATE,   1'b1, 1'b0, 32'd600,        1'b0, 1'b0, 1'b1, 9'd30,  1'b0, '{1'b0, 1'b0, 1'b0}},
		// light not fitted: presence is ignored
		'{OP_UPDATE,   1'b1, 1'b1, 32'd700,        1'b0, 1'b1, 1'b0, 9'd30,  1'b1, '{1'b0, 1'b0, 1'b1}},
		// hold beyond the nominal range, tested at its edge
		'{OP_UPDATE,   1'b1, 1'b1, 32'd1000,       1'b0, 1'b1, 1'b1, 9'd511, 1'b0, '{1'b0, 1'b0, 1'b0}},
		'{OP_UPDATE,   1'b1, 1'b0, 32'd512000,     1'b0, 1'b0, 1'b1, 9'd511, 1'b1, '{1'b1, 1'b0, 1'b1}},
		'{OP_UPDATE,   1'b1, 1'b0, 32'd512001,     1'b0, 1'b0, 1'b1, 9'd511, 1'b1, '{1'b0, 1'b1, 1'b1}}
	};

	// Register settings and lengths of the random phases
	logic       phase_fit   [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
	logic [8:0] phase_hold  [PHASES] = '{9'd30, 9'd0, 9'd1, 9'd300, 9'd300, 9'd511, 9'd2, 9'd511};
	int         phase_words [PHASES] = '{120, 110, 120, 60, 120, 130, 110, 60};

	// Counts a fault; true while the report budget lasts
	function automatic bit report_ok();
		fault_count++;
		return fault_count <= 10;
	endfunction

	// Advances the mirror by one word and returns the result it should produce
	function automatic result_t next_light(input item_t w);
		result_t     r;
		logic        was;
		logic        go_on;
		logic        go_off;
		logic        held;
		logic [31:0] hold_ms;
		was    = lamp_lit;
		go_on  = 1'b0;
		go_off = 1'b0;
		case (w.operation)
			OP_UPDATE: begin
				if (!fitted) begin
					room_busy = 1'b0;
					lamp_lit  = 1'b0;
				end else begin
					room_busy = w.radar_online && w.occupied;
					if (room_busy) begin
						seen_ms = w.now_ms;
					end else if (hush_until_clear) begin
						hush_until_clear = 1'b0;
						seen_ms          = 32'd0;
					end
					hold_ms  = {23'd0, hold_s} * 32'd1000;
					// modulo 2^32 distance; zero time stamp means nothing seen
					held     = (seen_ms != 32'd0) && ((w.now_ms - seen_ms) <= hold_ms);
					lamp_lit = hand_on ||
						(auto_mode_on && !hush_until_clear && (room_busy || held));
				end
			end
			OP_TURN_ON:  go_on = 1'b1;
			OP_TURN_OFF: go_off = 1'b1;
			OP_TOGGLE: begin
				if (lamp_lit) go_off = 1'b1;
				else go_on = 1'b1;
			end
			OP_SET_AUTO: begin
				auto_mode_on = w.auto_enable;
				if (!w.auto_enable) begin
					hush_until_clear = 1'b0;
					seen_ms          = 32'd0;
					lamp_lit         = hand_on;
				end else begin
					lamp_lit = hand_on || (!hush_until_clear && room_busy);
				end
			end
			default: ;
		endcase
		if (go_on) begin
			hand_on          = 1'b1;
			hush_until_clear = 1'b0;
			lamp_lit         = 1'b1;
		end
		if (go_off) begin
			hand_on          = 1'b0;
			hush_until_clear = room_busy;
			seen_ms          = 32'd0;
			lamp_lit         = 1'b0;
		end
		r.light_on    = lamp_lit;
		r.changed     = lamp_lit != was;
		r.auto_active = auto_mode_on;
		return r;
	endfunction

	// Mostly sensor updates with occupancy in runs and time creeping around the hold edge
	function automatic item_t draw_word();
		item_t       w;
		int unsigned pick;
		int unsigned k;
		logic [31:0] hold_ms;
		hold_ms        = {23'd0, hold_s} * 32'd1000;
		w.radar_online = 1'($urandom_range(0, 1));
		w.occupied     = 1'($urandom_range(0, 1));
		w.now_ms       = $urandom;
		w.auto_enable  = 1'($urandom_range(0, 1));
		pick           = $urandom_range(0, 99);
		if (pick < 58) begin
			w.operation = OP_UPDATE;
			if ($urandom_range(0, 5) == 0) busy_run = !busy_run;
			w.occupied     = busy_run ^ ($urandom_range(0, 19) == 0);
			w.radar_online = $urandom_range(0, 11) != 0;
			k = $urandom_range(0, 19);
			if (k == 0) sim_ms = $urandom;
			else if (k == 1) sim_ms = 32'd0;
			else if (k == 2 && seen_ms != 32'd0) sim_ms = seen_ms + hold_ms;
			else if (k == 3 && seen_ms != 32'd0) sim_ms = seen_ms + hold_ms + 32'd1;
			else sim_ms = sim_ms + $urandom_range(0, hold_ms / 3 + 200);
			w.now_ms = sim_ms;
		end else if (pick < 68) begin
			w.operation = OP_TURN_ON;
		end else if (pick < 78) begin
			w.operation = OP_TURN_OFF;
		end else if (pick < 88) begin
			w.operation = OP_TOGGLE;
		end else if (pick < 96) begin
			w.operation   = OP_SET_AUTO;
			w.auto_enable = $urandom_range(0, 3) != 0;
		end else begin
			w.operation = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		end
		return w;
	endfunction

	// Offers one word and holds it until taken; the expectation is queued at acceptance
	task automatic send_word(input item_t w, input logic typed, input result_t typed_want);
		result_t p;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = {5'd0, w.auto_enable, w.now_ms, w.occupied, w.radar_online};
		s_tuser  = w.operation;
		do @(posedge clk); while (!s_tready);
		p = next_light(w);
		expected_lights.push_back(typed ? typed_want : p);
		sent_words++;
		op_seen[w.operation]++;
	endtask

	// Sender stops and waits for every outstanding result
	task automatic wait_for_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (expected_lights.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = addr;
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Writes both registers, mirrors them, and reads them back
	task automatic set_registers(input logic fit_v, input logic [8:0] hold_v);
		logic [31:0] back;
		apb_access(1'b1, {REG_LIGHT_INSTALLED, 2'b00}, {31'd0, fit_v}, back);
		apb_access(1'b1, {REG_HOLD_SECONDS, 2'b00}, {23'd0, hold_v}, back);
		fitted = fit_v;
		hold_s = hold_v;
		cfg_writes++;
		apb_access(1'b0, {REG_LIGHT_INSTALLED, 2'b00}, 32'd0, back);
		if (back !== {31'd0, fit_v}) begin
			if (report_ok()) $display("light_installed read back %h, wrote %b", back, fit_v);
		end
		apb_access(1'b0, {REG_HOLD_SECONDS, 2'b00}, 32'd0, back);
		if (back !== {23'd0, hold_v}) begin
			if (report_ok()) $display("hold_seconds read back %h, wrote %0d", back, hold_v);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: changes its stall pattern now and then, and serves long hold-off requests
	initial begin : receiver
		int          hold_left;
		int          mode;
		int          mode_left;
		int          served;
		int unsigned tick;
		m_tready  = 1'b0;
		hold_left = 0;
		mode      = 0;
		mode_left = 0;
		served    = 0;
		tick      = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (stall_requests != served) begin
				served    = stall_requests;
				hold_left = HOLD_OFF;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else begin
				case (mode)
					0: m_tready = 1'b1;
					1: m_tready = 1'($urandom_range(0, 1));
					2: m_tready = (tick % 7) >= 3;
					default: m_tready = $urandom_range(0, 7) != 0;
				endcase
			end
		end
	end

	// Result checker: each word taken is compared with the oldest expectation
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_lights.size() == 0) begin
				if (report_ok()) $display("result word %b with nothing expected", m_tdata[2:0]);
			end else begin
				want = expected_lights.pop_front();
				checked_results++;
				if (m_tdata[0] !== want.light_on || m_tdata[1] !== want.changed ||
					m_tdata[2] !== want.auto_active) begin
					if (report_ok())
						$display("result %0d: expected light %b changed %b auto %b, got %b %b %b",
							checked_results, want.light_on, want.changed, want.auto_active,
							m_tdata[0], m_tdata[1], m_tdata[2]);
				end
			end
		end
	end

	// Watchdog: ends the run when no word has moved on either stream for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
			else idle++;
			if (s_tvalid && !s_tready) in_stalls++;
		end
		$display("no word moved for %0d cycles, %0d results outstanding", IDLE_LIMIT,
			expected_lights.size());
		$display("FAIL presence_light_hold_controller");
		$finish;
	end

	initial begin : stimulus
		item_t w;
		int    burst_left;
		bit    steady;
		int    spare_total;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 40'd0;
		s_tuser  = OP_UPDATE;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = 3'd0;
		pwdata   = 32'd0;
		sim_ms   = 32'd0;
		busy_run = 1'b0;
		foreach (op_seen[i]) op_seen[i] = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed plan, reset registers until the rows that set them
		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (plan[i].cfg) begin
				wait_for_results();
				set_registers(plan[i].fit, plan[i].hold);
			end
			w.operation    = plan[i].op;
			w.radar_online = plan[i].radar;
			w.occupied     = plan[i].occ;
			w.now_ms       = plan[i].now;
			w.auto_enable  = plan[i].en;
			send_word(w, plan[i].typed, plan[i].want);
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) @(negedge clk) s_tvalid = 1'b0;
		end

		// Random phases, each after a full drain and a fresh register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_for_results();
			set_registers(phase_fit[ph], phase_hold[ph]);
			sim_ms     = (ph == 2) ? 32'hFFFF_FFFF - $urandom_range(0, 50000) : $urandom;
			busy_run   = 1'b0;
			burst_left = 0;
			steady     = (ph == 0) || (ph == 4);
			// long receiver hold-off with the sender offering back to back
			if (ph == 4) stall_requests++;
			for (int n = 0; n < phase_words[ph]; n++) begin
				if (burst_left == 0) begin
					if (!steady) repeat ($urandom_range(1, 12)) @(negedge clk) s_tvalid = 1'b0;
					burst_left = $urandom_range(1, 40);
				end
				burst_left--;
				send_word(draw_word(), 1'b0, '0);
			end
		end

		wait_for_results();
		repeat (10) @(posedge clk);
		spare_total = 0;
		for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++) spare_total += op_seen[c];
		$display("Covered %0d words: %0d updates, %0d manual commands, %0d unused codes, %0d settings",
			sent_words, op_seen[OP_UPDATE],
			op_seen[OP_TURN_ON] + op_seen[OP_TURN_OFF] + op_seen[OP_TOGGLE] + op_seen[OP_SET_AUTO],
			spare_total, cfg_writes);
		$display("%0d results checked, input held back %0d cycles, %0d faults",
			checked_results, in_stalls, fault_count);
		if (fault_count == 0 && expected_lights.size() == 0) begin
			$display("PASS presence_light_hold_controller");
		end else begin
			$display("FAIL presence_light_hold_controller");
		end
		$finish;
	end

endmodule
